// ----- hw/rtl/itf_pkg.sv -----
// shared constants, types and helper functions for the imu tilt filter
package itf_pkg;

	// cordic configuration
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_ENTRIES      = 24;
	localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
		CORDIC_ITERATIONS : ATAN_ENTRIES;
	localparam int CORDIC_W          = 36;
	localparam int ANGLE_ACC_W       = 34;
	localparam int IN_SHIFT          = 14;
	localparam logic [29:0] INV_K_Q30 = 30'd652032874;

	// constant divider for the gyro step (1000 ms times 4096)
	localparam int DIV_W       = 61;
	localparam int DIV_QBITS   = 40;
	localparam longint DIV_CONST = 64'd4096000;

	// 4096000 = 2^15 * 125: shift first, then multiply by ceil(2^50 / 125)
	localparam int DIV_PRE_SHIFT   = 15;
	localparam int DIV_M_W         = DIV_W - DIV_PRE_SHIFT;
	localparam int DIV_RECIP_W     = 44;
	localparam int DIV_RECIP_SHIFT = 50;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 44'd9007199254741;

	// register defaults
	localparam logic [23:0] SCALE_RESET = 24'd256140;
	localparam logic [16:0] ALPHA_RESET = 17'd62915;
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;

	// register indexes
	typedef enum logic [2:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_OFFSET_Z = 3'd2,
		REG_SCALE    = 3'd3,
		REG_ALPHA    = 3'd4
	} reg_idx_t;

	typedef logic signed [CORDIC_W-1:0]    cordic_val_t;
	typedef logic signed [ANGLE_ACC_W-1:0] cordic_ang_t;

	// arctangent table in q8.24 degrees
	function automatic cordic_ang_t atan_q24(input logic [4:0] idx);
		cordic_ang_t r;
		case (idx)
			5'd0:  r = 34'sd754974720;
			5'd1:  r = 34'sd445687602;
			5'd2:  r = 34'sd235489089;
			5'd3:  r = 34'sd119537938;
			5'd4:  r = 34'sd60000934;
			5'd5:  r = 34'sd30029717;
			5'd6:  r = 34'sd15018523;
			5'd7:  r = 34'sd7509720;
			5'd8:  r = 34'sd3754917;
			5'd9:  r = 34'sd1877466;
			5'd10: r = 34'sd938734;
			5'd11: r = 34'sd469367;
			5'd12: r = 34'sd234684;
			5'd13: r = 34'sd117342;
			5'd14: r = 34'sd58671;
			5'd15: r = 34'sd29336;
			5'd16: r = 34'sd14668;
			5'd17: r = 34'sd7334;
			5'd18: r = 34'sd3667;
			5'd19: r = 34'sd1833;
			5'd20: r = 34'sd917;
			5'd21: r = 34'sd458;
			5'd22: r = 34'sd229;
			5'd23: r = 34'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/itf_if.sv -----
// sample and result channel interfaces
interface itf_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic        [15:0] elapsed_ms;

	modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		elapsed_ms, input ready);
	modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		elapsed_ms, output ready);
endinterface

interface itf_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] tilt_x;
	logic signed [31:0] tilt_y;
	logic signed [31:0] heading_z;

	modport source (output valid, tilt_x, tilt_y, heading_z, input ready);
	modport sink (input valid, tilt_x, tilt_y, heading_z, output ready);
endinterface

// ----- hw/rtl/itf_cordic.sv -----
// vectoring cordic, one micro-rotation per cycle
module itf_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  itf_pkg::cordic_val_t x0,
	input  itf_pkg::cordic_val_t y0,
	output logic                 busy,
	output logic                 done,
	output itf_pkg::cordic_val_t x,
	output itf_pkg::cordic_ang_t z
);

	itf_pkg::cordic_val_t x_q, y_q;
	itf_pkg::cordic_ang_t z_q;
	logic [4:0]           i_q;
	logic                 busy_q, done_q;
	itf_pkg::cordic_val_t xs, ys;
	itf_pkg::cordic_ang_t at;

	// shifted terms for this rotation
	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = itf_pkg::atan_q24(i_q);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && !start && (i_q == 5'(itf_pkg::CORDIC_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(itf_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: drive y toward zero
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[itf_pkg::CORDIC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign x    = x_q;
	assign z    = z_q;

endmodule

// ----- hw/rtl/itf_divk.sv -----
// divider by the fixed gyro step constant: a shift, then a reciprocal multiply in four partial products
module itf_divk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [itf_pkg::DIV_W-1:0]         dividend,
	output logic                              busy,
	output logic                              done,
	output logic [itf_pkg::DIV_QBITS-1:0]     quot
);

	localparam int ACC_W = itf_pkg::DIV_M_W + itf_pkg::DIV_RECIP_W;
	localparam int MH    = itf_pkg::DIV_M_W / 2;
	localparam int CH    = itf_pkg::DIV_RECIP_W / 2;

	logic [itf_pkg::DIV_M_W-1:0] m_q;
	logic [ACC_W-1:0]            acc_q;
	logic [1:0]                  cnt_q;
	logic                        busy_q, done_q;
	logic [MH-1:0]               op_a;
	logic [CH-1:0]               op_b;
	logic [MH+CH-1:0]            prod;
	logic [ACC_W-1:0]            part;

	// one half of the shifted dividend times one half of the reciprocal
	always_comb begin
		op_a = cnt_q[1] ? m_q[itf_pkg::DIV_M_W-1:MH] : m_q[MH-1:0];
		op_b = cnt_q[0] ? itf_pkg::DIV_RECIP[itf_pkg::DIV_RECIP_W-1:CH] :
			itf_pkg::DIV_RECIP[CH-1:0];
		prod = op_a * op_b;
		part = ACC_W'(prod) << ((cnt_q[1] ? MH : 0) + (cnt_q[0] ? CH : 0));
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// accumulate the partial products
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= dividend[itf_pkg::DIV_W-1:itf_pkg::DIV_PRE_SHIFT];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = acc_q[itf_pkg::DIV_RECIP_SHIFT +: itf_pkg::DIV_QBITS];

endmodule

// ----- hw/rtl/imu_complementary_tilt_filter.sv -----
// top level: registers, sequencer and shared datapath of the tilt filter
// One sample beat is taken at a time; the input is ready again only once the
// result has gone to the output register. The single cordic unit sets most of
// the latency: up to four vectoring passes (a magnitude and an angle for each of
// the two tilt axes); a tilt axis whose atan2 numerator is zero skips its angle
// pass. Each of the three gyro axes takes two multiplies, then the rate-time
// product is divided by a shift and a reciprocal multiply. The result sits in an
// output register, so the next sample can be taken while it waits; if it is still
// waiting when the next sample is finished, the sequencer holds and the input
// stalls. Configuration is an APB port, registers at byte addresses 4*i.
module imu_complementary_tilt_filter (
	input  logic        clk,
	input  logic        arst_n,
	itf_sample_if.sink  sample,
	itf_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_GM1  = 16'h0002,
		S_GM2  = 16'h0004,
		S_GABS = 16'h0008,
		S_GDIV = 16'h0010,
		S_C1L  = 16'h0020,
		S_C1W  = 16'h0040,
		S_CMAG = 16'h0080,
		S_C2L  = 16'h0100,
		S_C2W  = 16'h0200,
		S_CRND = 16'h0400,
		S_BL1  = 16'h0800,
		S_BL2  = 16'h1000,
		S_BL3  = 16'h2000,
		S_ZSAT = 16'h4000,
		S_DONE = 16'h8000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [19:0] off_x_q, off_y_q, off_z_q;
	logic [23:0] scale_q;
	logic [16:0] alpha_q;
	logic        wr_en;
	itf_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = itf_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			scale_q <= itf_pkg::SCALE_RESET;
			alpha_q <= itf_pkg::ALPHA_RESET;
		end else if (wr_en) begin
			case (widx)
				itf_pkg::REG_OFFSET_X: off_x_q <= pwdata[19:0];
				itf_pkg::REG_OFFSET_Y: off_y_q <= pwdata[19:0];
				itf_pkg::REG_OFFSET_Z: off_z_q <= pwdata[19:0];
				itf_pkg::REG_SCALE:    scale_q <= pwdata[23:0];
				itf_pkg::REG_ALPHA:    alpha_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (widx)
			itf_pkg::REG_OFFSET_X: prdata = {12'd0, off_x_q};
			itf_pkg::REG_OFFSET_Y: prdata = {12'd0, off_y_q};
			itf_pkg::REG_OFFSET_Z: prdata = {12'd0, off_z_q};
			itf_pkg::REG_SCALE:    prdata = {8'd0, scale_q};
			itf_pkg::REG_ALPHA:    prdata = {15'd0, alpha_q};
			default:               prdata = '0;
		endcase
	end

	// sample and working registers
	logic signed [15:0] gyro_q [3];
	logic signed [15:0] ax_q, ay_q, az_q;
	logic        [15:0] ms_q;
	logic signed [31:0] ang_q [3];
	logic signed [41:0] g_q [3];
	logic signed [31:0] tilt_q [2];
	logic        [1:0]  axis_q;
	logic               t_q;
	logic signed [45:0] p1_q;
	logic signed [61:0] p2_q;
	logic               neg_q;
	logic        [31:0] mag_q;
	logic signed [59:0] m1_q;
	logic signed [61:0] sum_q;
	logic               res_valid_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;

	// gyro bias removal, scale and time product for the current axis
	logic        [19:0] off_sel;
	logic signed [20:0] diff;
	logic signed [45:0] p1;
	logic signed [61:0] p2;
	logic        [61:0] p2_mag;
	logic [itf_pkg::DIV_W-1:0] div_in;

	always_comb begin
		case (axis_q)
			2'd0:    off_sel = off_x_q;
			2'd1:    off_sel = off_y_q;
			default: off_sel = off_z_q;
		endcase
		diff   = $signed({gyro_q[axis_q][15], gyro_q[axis_q], 4'h0}) -
			$signed({off_sel[19], off_sel});
		p1     = diff * $signed({1'b0, scale_q});
		p2     = p1_q * $signed({1'b0, ms_q});
		p2_mag = p2_q[61] ? 62'(-p2_q) : 62'(p2_q);
		div_in = p2_mag[itf_pkg::DIV_W-1:0] +
			itf_pkg::DIV_W'(itf_pkg::DIV_CONST / 2);
	end

	// divider
	logic                          div_start, div_busy, div_done;
	logic [itf_pkg::DIV_QBITS-1:0] div_q;
	logic signed [41:0]            step;
	logic signed [41:0]            g_new;

	assign div_start = (state_q == S_GABS);
	assign step  = neg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
	assign g_new = 42'(ang_q[axis_q]) + step;

	itf_divk u_divk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_q)
	);

	// cordic operands for the current tilt axis
	logic signed [16:0]   num;
	logic signed [16:0]   a_s, b_s;
	logic        [16:0]   a_abs, b_abs;
	logic                 cor_start, cor_busy, cor_done;
	itf_pkg::cordic_val_t cor_x0, cor_y0, cor_x;
	itf_pkg::cordic_ang_t cor_z;
	logic        [31:0]   xm;
	logic        [61:0]   mag_prod;
	logic        [33:0]   z_abs;
	logic        [25:0]   z_rnd;
	logic signed [31:0]   tilt_new;

	always_comb begin
		num   = t_q ? 17'(ay_q) : -17'(ax_q);
		a_s   = t_q ? 17'(ax_q) : 17'(ay_q);
		b_s   = 17'(az_q);
		a_abs = a_s[16] ? 17'(-a_s) : 17'(a_s);
		b_abs = b_s[16] ? 17'(-b_s) : 17'(b_s);
		cor_start = (state_q == S_C1L) || (state_q == S_C2L);
		if (state_q == S_C2L) begin
			cor_x0 = itf_pkg::cordic_val_t'({4'd0, mag_q});
			cor_y0 = itf_pkg::cordic_val_t'(num) <<< itf_pkg::IN_SHIFT;
		end else begin
			cor_x0 = itf_pkg::cordic_val_t'({1'b0, b_abs}) << itf_pkg::IN_SHIFT;
			cor_y0 = itf_pkg::cordic_val_t'({1'b0, a_abs}) << itf_pkg::IN_SHIFT;
		end
		xm       = cor_x[itf_pkg::CORDIC_W-1] ? 32'd0 : cor_x[31:0];
		mag_prod = 62'(xm) * 62'(itf_pkg::INV_K_Q30) + 62'(64'd1 << 29);
		z_abs    = cor_z[33] ? 34'(-cor_z) : 34'(cor_z);
		z_rnd    = 26'((z_abs + 34'd128) >> 8);
		tilt_new = cor_z[33] ? -$signed({6'd0, z_rnd}) : $signed({6'd0, z_rnd});
	end

	itf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.busy   (cor_busy),
		.done   (cor_done),
		.x      (cor_x),
		.z      (cor_z)
	);

	// blend arithmetic
	logic        [16:0] alpha_c, beta;
	logic signed [59:0] m1;
	logic signed [61:0] sum;
	logic        [61:0] sum_abs;
	logic        [45:0] sum_rnd;
	logic signed [47:0] blend;

	always_comb begin
		alpha_c = (alpha_q > itf_pkg::ALPHA_ONE) ? itf_pkg::ALPHA_ONE : alpha_q;
		beta    = itf_pkg::ALPHA_ONE - alpha_c;
		m1      = $signed({1'b0, alpha_c}) * g_q[axis_q];
		sum     = 62'(m1_q) + 62'(tilt_q[axis_q[0]]) * $signed({1'b0, beta});
		sum_abs = sum_q[61] ? 62'(-sum_q) : 62'(sum_q);
		sum_rnd = 46'((sum_abs + 62'd32768) >> 16);
		blend   = sum_q[61] ? -$signed({2'b00, sum_rnd}) : $signed({2'b00, sum_rnd});
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			t_q         <= 1'b0;
			res_valid_q <= 1'b0;
			ang_q[0]    <= '0;
			ang_q[1]    <= '0;
			ang_q[2]    <= '0;
		end else begin
			if (state_q == S_DONE && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						axis_q  <= '0;
						state_q <= S_GM1;
					end
				end
				S_GM1:  state_q <= S_GM2;
				S_GM2:  state_q <= S_GABS;
				S_GABS: state_q <= S_GDIV;
				S_GDIV: begin
					if (div_done) begin
						if (axis_q == 2'd2) begin
							t_q     <= 1'b0;
							state_q <= S_C1L;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_GM1;
						end
					end
				end
				S_C1L: state_q <= S_C1W;
				S_C1W: begin
					if (cor_done) begin
						state_q <= S_CMAG;
					end
				end
				S_CMAG: begin
					if (num == 17'sd0) begin
						t_q     <= 1'b1;
						axis_q  <= '0;
						state_q <= t_q ? S_BL1 : S_C1L;
					end else begin
						state_q <= S_C2L;
					end
				end
				S_C2L: state_q <= S_C2W;
				S_C2W: begin
					if (cor_done) begin
						state_q <= S_CRND;
					end
				end
				S_CRND: begin
					t_q     <= 1'b1;
					axis_q  <= '0;
					state_q <= t_q ? S_BL1 : S_C1L;
				end
				S_BL1: state_q <= S_BL2;
				S_BL2: state_q <= S_BL3;
				S_BL3: begin
					ang_q[axis_q] <= itf_pkg::sat32(blend);
					if (axis_q == 2'd1) begin
						state_q <= S_ZSAT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_BL1;
					end
				end
				S_ZSAT: begin
					ang_q[2] <= itf_pkg::sat32(48'(g_q[2]));
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				gyro_q[0] <= sample.gyro_x;
				gyro_q[1] <= sample.gyro_y;
				gyro_q[2] <= sample.gyro_z;
				ax_q      <= sample.accel_x;
				ay_q      <= sample.accel_y;
				az_q      <= sample.accel_z;
				ms_q      <= sample.elapsed_ms;
			end
			S_GM1:  p1_q <= p1;
			S_GM2:  p2_q <= p2;
			S_GABS: neg_q <= p2_q[61];
			S_GDIV: begin
				if (div_done) begin
					g_q[axis_q] <= g_new;
				end
			end
			S_CMAG: begin
				mag_q <= mag_prod[61:30];
				if (num == 17'sd0) begin
					tilt_q[t_q] <= '0;
				end
			end
			S_CRND: tilt_q[t_q] <= tilt_new;
			S_BL1:  m1_q <= m1;
			S_BL2:  sum_q <= sum;
			S_DONE: begin
				if (!res_valid_q || result.ready) begin
					res_x_q <= ang_q[0];
					res_y_q <= ang_q[1];
					res_z_q <= ang_q[2];
				end
			end
			default: ;
		endcase
	end

	assign sample.ready     = (state_q == S_IDLE);
	assign result.valid     = res_valid_q;
	assign result.tilt_x    = res_x_q;
	assign result.tilt_y    = res_y_q;
	assign result.heading_z = res_z_q;

`ifndef SYNTH
	// divider and cordic never run at the same time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && cor_busy))
		else $error("divider and cordic busy together");

	// no second sample beat while one is in work
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while busy");

	// a result appears only when the sequencer finishes
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == S_DONE))
		else $error("result valid without finish");
`endif

endmodule
